// ----- src/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// Columnar transposition cipher package
// Shared types, register indexes and the key byte selector.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int KEY_REGS  = 4;
   localparam int KEY_W     = KEY_REGS * 64;
   localparam int DESC_NW   = 7;
   localparam int DESC_FW   = 6;
   localparam int OQ_DEPTH  = 4;
   localparam int OQ_PW     = 2;
   localparam int OQ_CW     = 3;

   typedef enum logic [2:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_MODE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             decrypt;
   } cfg_type;

   // One finished message waiting for the back end.
   typedef struct packed {
      logic [DESC_NW-1:0] n;
      logic [DESC_FW-1:0] long_cols;
      logic [DESC_NW-1:0] rows;
      logic               ovf;
      logic               bank;
   } desc_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       overflow;
   } result_type;

   function automatic logic [7:0] key_byte(logic [KEY_W-1:0] key, logic [4:0] idx);
      return key[idx*8 +: 8];
   endfunction

endpackage

// ----- src/ctc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ----- src/ctc_desc_q.sv -----
// ----------------------------------------------------------------------------
// Message descriptor queue
// Two entry queue between the loader and the permutation engine.
// ----------------------------------------------------------------------------
module ctc_desc_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctc_pkg::desc_type push_desc,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ctc_pkg::desc_type head
);
   import ctc_pkg::*;

   desc_type   slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("Descriptor pushed into a full queue.");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("Descriptor popped from an empty queue.");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("Descriptor count out of range.");
`endif
endmodule

// ----- src/ctc_front.sv -----
// ----------------------------------------------------------------------------
// Message loader
// Stores incoming bytes into one of two banks and closes each message.
// ----------------------------------------------------------------------------
module ctc_front #(
   parameter int MSG_MAX = 64,
   parameter int KEY_LEN = 32,
   localparam int AW = $clog2(MSG_MAX),
   localparam int NW = $clog2(MSG_MAX + 1),
   localparam int CW = $clog2(KEY_LEN)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              wr_en,
   output logic [AW:0]       wr_addr,
   output logic [7:0]        wr_data,
   output logic              desc_push,
   output ctc_pkg::desc_type desc
);
   import ctc_pkg::*;

   logic [NW-1:0] cnt_ff, cnt_in, cnt_nx;
   logic [CW-1:0] col_ff, col_in, col_nx;
   logic [NW-1:0] row_ff, row_in, row_nx;
   logic          ovf_ff, ovf_in;
   logic          bank_ff, bank_in;
   logic          stored;

   always_comb begin
      stored = (cnt_ff < NW'(MSG_MAX));
      cnt_nx = cnt_ff;
      col_nx = col_ff;
      row_nx = row_ff;
      if (stored) begin
         cnt_nx = cnt_ff + 1'b1;
         if (col_ff == CW'(KEY_LEN - 1)) begin
            col_nx = '0;
            row_nx = row_ff + 1'b1;
         end else begin
            col_nx = col_ff + 1'b1;
         end
      end

      wr_en   = accept && stored;
      wr_addr = {bank_ff, cnt_ff[AW-1:0]};
      wr_data = in_byte;

      desc_push      = accept && in_last;
      desc.n         = DESC_NW'(cnt_nx);
      desc.long_cols = (col_nx == '0) ? DESC_FW'(KEY_LEN) : DESC_FW'(col_nx);
      desc.rows      = (col_nx == '0) ? DESC_NW'(row_nx) : DESC_NW'(row_nx) + 1'b1;
      desc.ovf       = ovf_ff || !stored;
      desc.bank      = bank_ff;

      cnt_in  = cnt_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      ovf_in  = ovf_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (in_last) begin
            cnt_in  = '0;
            col_in  = '0;
            row_in  = '0;
            ovf_in  = 1'b0;
            bank_in = ~bank_ff;
         end else begin
            cnt_in = cnt_nx;
            col_in = col_nx;
            row_in = row_nx;
            ovf_in = ovf_ff || !stored;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         ovf_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         ovf_ff  <= ovf_in;
         bank_ff <= bank_in;
      end
   end

`ifndef SYNTHESIS
   a_ovf_on_drop: assert property (@(posedge clock) disable iff (reset)
      accept && !in_last && (cnt_ff == NW'(MSG_MAX)) |=> ovf_ff)
      else $error("Dropped item did not set the overflow flag.");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MSG_MAX)) else $error("Byte count beyond the store size.");
   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      desc_push |=> (bank_ff != $past(bank_ff)) && (cnt_ff == '0))
      else $error("Message end did not switch banks.");
`endif
endmodule

// ----- src/ctc_back.sv -----
// ----------------------------------------------------------------------------
// Permutation engine
// Ranks the key columns, then reads the stored message in permuted order.
// ----------------------------------------------------------------------------
module ctc_back #(
   parameter int MSG_MAX = 64,
   parameter int KEY_LEN = 32,
   localparam int AW = $clog2(MSG_MAX),
   localparam int NW = $clog2(MSG_MAX + 1),
   localparam int CW = $clog2(KEY_LEN)
) (
   input  logic              clock,
   input  logic              reset,
   input  ctc_pkg::cfg_type  cfg,
   input  logic              desc_valid,
   input  ctc_pkg::desc_type desc,
   output logic              desc_pop,
   output logic              rd_en,
   output logic [AW:0]       rd_addr,
   input  logic [7:0]        rd_data,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last,
   output logic              rsp_overflow
);
   import ctc_pkg::*;

   back_state_type state_ff, state_in;

   logic [CW-1:0] rc_ff, rc_in;
   logic [CW-1:0] colord_ff [KEY_LEN];
   logic [AW-1:0] start_ff  [KEY_LEN];
   logic [CW:0]   t_ff, t_in;
   logic [NW-1:0] r_ff, r_in;
   logic [NW-1:0] k_ff, k_in;
   logic [CW-1:0] dc_ff, dc_in;
   logic          inflight_ff, last_ff, ovf_ff;

   result_type     oq_ff [OQ_DEPTH];
   logic [OQ_PW-1:0] wp_ff, rp_ff;
   logic [OQ_CW-1:0] cnt_ff, cnt_in;

   logic [KEY_LEN-1:0] lt_vec, part_vec;
   logic [7:0]         kc;
   logic [CW-1:0]      rank;
   logic [12:0]        start_full;
   logic [CW-1:0]      col;
   logic [DESC_NW-1:0] len;
   logic [12:0]        cell_idx;
   logic               r_hit, credit, go, issue, msg_done, rank_we, oq_rd;

   // Column ranking: one column per cycle against all key bytes.
   always_comb begin
      kc = key_byte(cfg.key, 5'(rc_ff));
      for (int j = 0; j < KEY_LEN; j++) begin
         lt_vec[j] = (key_byte(cfg.key, 5'(j)) < kc) ||
                     ((key_byte(cfg.key, 5'(j)) == kc) && (CW'(j) < rc_ff));
         part_vec[j] = lt_vec[j] && (DESC_FW'(j) < desc.long_cols);
      end
      rank       = CW'($countones(lt_vec));
      start_full = 13'(rank) * 13'(desc.rows - 1'b1) + 13'($countones(part_vec));
   end

   always_comb begin
      msg_done = (DESC_NW'(k_ff) == desc.n);
      col      = colord_ff[t_ff[CW-1:0]];
      len      = (DESC_FW'(col) < desc.long_cols) ? desc.rows : desc.rows - 1'b1;
      r_hit    = (DESC_NW'(r_ff) < len);
      credit   = ({1'b0, cnt_ff} + {{OQ_CW{1'b0}}, inflight_ff}) < (OQ_CW+1)'(OQ_DEPTH);
      cell_idx = 13'(r_ff) * 13'(KEY_LEN) + 13'(col);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (desc_valid) state_in = ST_RANK;
         ST_RANK: if (rc_ff == CW'(KEY_LEN - 1)) state_in = ST_EMIT;
         ST_EMIT: if (msg_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rank_we  = 1'b0;
      go       = 1'b0;
      desc_pop = 1'b0;
      case (state_ff)
         ST_RANK: rank_we = 1'b1;
         ST_EMIT: begin
            go       = !msg_done && credit;
            desc_pop = msg_done;
         end
         default: ;
      endcase
      issue = go && (cfg.decrypt || r_hit);
      rd_en = issue;
      if (cfg.decrypt) begin
         rd_addr = {desc.bank, start_ff[dc_ff] + AW'(r_ff)};
      end else begin
         rd_addr = {desc.bank, cell_idx[AW-1:0]};
      end
   end

   always_comb begin
      rc_in = (state_ff == ST_RANK) ? rc_ff + 1'b1 : '0;
      t_in  = t_ff;
      r_in  = r_ff;
      k_in  = k_ff;
      dc_in = dc_ff;
      if (state_ff == ST_IDLE) begin
         t_in  = '0;
         r_in  = '0;
         k_in  = '0;
         dc_in = '0;
      end else if (go) begin
         if (cfg.decrypt) begin
            if (dc_ff == CW'(KEY_LEN - 1)) begin
               dc_in = '0;
               r_in  = r_ff + 1'b1;
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end else if (r_hit && (DESC_NW'(r_ff) + 1'b1 != len)) begin
            r_in = r_ff + 1'b1;
         end else begin
            r_in = '0;
            t_in = t_ff + 1'b1;
         end
         if (issue) begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_comb begin
      oq_rd     = rsp_pop && (cnt_ff != '0);
      cnt_in    = cnt_ff + {{(OQ_CW-1){1'b0}}, inflight_ff} - {{(OQ_CW-1){1'b0}}, oq_rd};
      rsp_empty = (cnt_ff == '0);
      {rsp_out_byte, rsp_out_last, rsp_overflow} = oq_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rc_ff       <= '0;
         t_ff        <= '0;
         r_ff        <= '0;
         k_ff        <= '0;
         dc_ff       <= '0;
         inflight_ff <= 1'b0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         rc_ff       <= rc_in;
         t_ff        <= t_in;
         r_ff        <= r_in;
         k_ff        <= k_in;
         dc_ff       <= dc_in;
         inflight_ff <= issue;
         cnt_ff      <= cnt_in;
         if (inflight_ff) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (oq_rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
      last_ff <= (DESC_NW'(k_ff) + 1'b1 == desc.n);
      ovf_ff  <= desc.ovf;
      if (inflight_ff) begin
         oq_ff[wp_ff] <= {rd_data, last_ff, ovf_ff};
      end
      if (rank_we) begin
         colord_ff[rank] <= rc_ff;
         start_ff[rc_ff] <= start_full[AW-1:0];
      end
   end

`ifndef SYNTHESIS
   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> cnt_ff < OQ_CW'(OQ_DEPTH))
      else $error("Read data arrived at a full result queue.");
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> DESC_NW'(k_ff) <= desc.n)
      else $error("More reads issued than bytes in the message.");
   a_emit_needs_desc: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> desc_valid)
      else $error("Engine busy without a message descriptor.");
`endif
endmodule

// ----- src/columnar_transposition_cipher.sv -----
// ----------------------------------------------------------------------------
// Columnar transposition cipher
// Loads a message, then emits it permuted by key column order.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_push / req_full  req_in_byte, req_in_last
//   rsp      out        rsp_pop / rsp_empty  rsp_out_byte, rsp_out_last, rsp_overflow
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Loading takes one item per cycle into one of two message banks while req_full is low.
// Each message then passes a start step, column ranking over all KEY_LEN key
// columns, one read per result byte, one extra step for every empty column in
// encrypt mode and a closing step; read data is registered in the RAM, then
// written to the result queue; reads pause while the four-entry queue has no room.
// A second message may load while the previous one is emitted; a third waits.
// Reset clears the key, mode and all counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module columnar_transposition_cipher #(
   parameter int MSG_MAX = 64,
   parameter int KEY_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import ctc_pkg::*;

   localparam int AW = $clog2(MSG_MAX);
   localparam int RAM_DEPTH = 2 * (2 ** AW);

   cfg_type  cfg_ff, cfg_in;
   desc_type push_desc, head;
   logic     accept, desc_push, desc_pop, q_full, q_empty;
   logic     wr_en, rd_en;
   logic [AW:0] wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY0: cfg_in.key[0*64 +: 64] = csr_data;
            CSR_KEY1: cfg_in.key[1*64 +: 64] = csr_data;
            CSR_KEY2: cfg_in.key[2*64 +: 64] = csr_data;
            CSR_KEY3: cfg_in.key[3*64 +: 64] = csr_data;
            CSR_MODE: cfg_in.decrypt = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctc_front #(.MSG_MAX(MSG_MAX), .KEY_LEN(KEY_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .desc_push (desc_push),
      .desc      (push_desc)
   );

   ctc_desc_q u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .pop       (desc_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   ctc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ctc_back #(.MSG_MAX(MSG_MAX), .KEY_LEN(KEY_LEN)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .desc_valid   (!q_empty),
      .desc         (head),
      .desc_pop     (desc_pop),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_overflow (rsp_overflow)
   );
endmodule
